FILE: hw/rtl/dpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

	// Buffer geometry
	localparam int BUFFER_BYTES  = 64;
	localparam int PAYLOAD_BYTES = 64;
	localparam int ADDR_W        = $clog2(BUFFER_BYTES);
	localparam int FILL_W        = $clog2(BUFFER_BYTES + 1);
	localparam int IDX_W         = 6;

	// Framing codes
	localparam logic [7:0] EOP_BYTE  = 8'h00;
	localparam logic [7:0] EEP_BYTE  = 8'hFF;
	localparam int         HDR_BYTES = 2;

	// Write request from the controller into the packet store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} dpd_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} dpd_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dpd_store.sv
`timescale 1ns / 1ps
`default_nettype none

module dpd_store (
	input  wire logic                   clk,
	input  wire dpd_pkg::dpd_wr_t       wr,
	input  wire logic [dpd_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                  rdata
);
	import dpd_pkg::*;

	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] rdata_q;

	// Write one byte, read one byte registered
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dpd_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      dest_address,
	output logic [7:0]                      proto_code,
	output logic [7:0]                      payload_byte,
	output logic [5:0]                      byte_index,
	output logic [5:0]                      payload_length,
	output logic                            has_payload,
	output logic                            ended_by_error,
	output logic                            packet_valid,
	output logic                            last,
	output dpd_pkg::dpd_wr_t                wr,
	output logic [dpd_pkg::ADDR_W-1:0]      raddr,
	input  wire logic [7:0]                 rdata
);
	import dpd_pkg::*;

	dpd_state_t        state_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_next;
	logic [7:0]        la_q;
	logic [7:0]        pid_q;
	logic              err_q;
	logic              has_q;
	logic              in_acc;
	logic              out_acc;
	logic              is_marker;
	logic              room;
	logic              last_w;
	logic [FILL_W-1:0] body;
	logic [IDX_W-1:0]  len_w;
	logic [IDX_W:0]    rsum;

	// Decode the incoming transaction
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_marker = (rx_byte == EOP_BYTE) || (rx_byte == EEP_BYTE);
	assign room      = (int'(fill_q) < BUFFER_BYTES);

	// Store data bytes while there is room
	always_comb begin
		wr.en   = in_acc && !is_marker && room;
		wr.addr = fill_q[ADDR_W-1:0];
		wr.data = rx_byte;
	end

	// Payload length, cut to the payload size
	always_comb begin
		body = fill_q - FILL_W'(HDR_BYTES);
		if (int'(body) > PAYLOAD_BYTES) begin
			len_w = IDX_W'(PAYLOAD_BYTES);
		end else begin
			len_w = IDX_W'(body);
		end
	end

	assign out_acc = out_valid && !out_stall;
	assign last_w  = !has_q || (idx_q == len_q - IDX_W'(1));

	// Next payload index drives the read address, so the registered read data lines up with idx_q
	always_comb begin
		if (state_q == ST_EMIT && out_acc && !last_w) begin
			idx_next = idx_q + IDX_W'(1);
		end else if (state_q == ST_EMIT) begin
			idx_next = idx_q;
		end else begin
			idx_next = '0;
		end
		rsum  = {1'b0, idx_next} + (IDX_W + 1)'(HDR_BYTES);
		raddr = ADDR_W'(rsum);
	end

	// Sequence packet collection and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && is_marker) begin
						fill_q <= '0;
						idx_q  <= '0;
						if (int'(fill_q) >= HDR_BYTES) begin
							state_q <= ST_EMIT;
						end
					end else if (wr.en) begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
				ST_EMIT: begin
					idx_q <= idx_next;
					if (out_acc && last_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture header bytes and packet attributes
	always_ff @(posedge clk) begin
		if (wr.en && fill_q == FILL_W'(0)) begin
			la_q <= rx_byte;
		end
		if (wr.en && fill_q == FILL_W'(1)) begin
			pid_q <= rx_byte;
		end
		if (in_acc && is_marker) begin
			err_q <= (rx_byte == EEP_BYTE);
			len_q <= len_w;
			has_q <= (len_w != '0);
		end
	end

	// Drive the result transaction
	assign out_valid       = (state_q == ST_EMIT);
	assign dest_address    = la_q;
	assign proto_code      = pid_q;
	assign payload_byte    = has_q ? rdata : 8'h00;
	assign byte_index      = idx_q;
	assign payload_length  = len_q;
	assign has_payload     = has_q;
	assign ended_by_error  = err_q;
	assign packet_valid    = !err_q;
	assign last            = last_w;

endmodule

`default_nettype wire

FILE: hw/rtl/delimited_packet_deframer_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// input    | in_valid, in_stall   | rx_byte
// output   | out_valid, out_stall | dest_address, proto_code, payload_byte,
//          |                      | byte_index, payload_length, has_payload,
//          |                      | ended_by_error, packet_valid, last
//
// A data byte is written into the 64-byte packet store while there is room; an
// end marker after at least the two header bytes sends the packet out at one
// result per cycle while out_stall is low, the rate of the store's single registered
// read port; input is stalled from the end marker until the last result is taken.
// Reset (arst_n low) empties the packet; the store itself needs no clearing.
// Output stalls hold the current result; no byte is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module delimited_packet_deframer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      dest_address,
	output logic [7:0]      proto_code,
	output logic [7:0]      payload_byte,
	output logic [5:0]      byte_index,
	output logic [5:0]      payload_length,
	output logic            has_payload,
	output logic            ended_by_error,
	output logic            packet_valid,
	output logic            last
);
	import dpd_pkg::*;

	dpd_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	// Control: collect, measure and emit packets
	dpd_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dest_address    (dest_address),
		.proto_code      (proto_code),
		.payload_byte    (payload_byte),
		.byte_index      (byte_index),
		.payload_length  (payload_length),
		.has_payload     (has_payload),
		.ended_by_error  (ended_by_error),
		.packet_valid    (packet_valid),
		.last            (last),
		.wr              (wr),
		.raddr           (raddr),
		.rdata           (rdata)
	);

	// Packet byte store
	dpd_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/dpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dpd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] payload_byte,
	input wire logic [5:0] byte_index,
	input wire logic [5:0] payload_length,
	input wire logic       has_payload,
	input wire logic       ended_by_error,
	input wire logic       packet_valid,
	input wire logic       last
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(byte_index))
		else $error("stalled result changed");

	// Block input while a packet is being emitted
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during emission");

	// Exactly one end kind per packet
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (packet_valid != ended_by_error))
		else $error("end kind flags disagree");

	// Empty payload gives one zero result
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_payload |-> last && payload_byte == 8'h00 &&
			payload_length == 6'd0 && byte_index == 6'd0)
		else $error("empty payload result malformed");

	// Advance to the next payload byte without a gap
	a_next_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid &&
			byte_index == $past(byte_index) + 6'd1)
		else $error("payload sequence broken");

endmodule

bind delimited_packet_deframer_unit dpd_checker u_dpd_checker (.*);

`default_nettype wire
